// ===== rtl/toy_sbox_cipher_ecb_cbc_ofb_macros.svh =====
// Assertion shorthands for the toy cipher; every check runs on clock and
// is switched off while reset is high.
`ifndef TOY_SBOX_CIPHER_ECB_CBC_OFB_MACROS_SVH
`define TOY_SBOX_CIPHER_ECB_CBC_OFB_MACROS_SVH

// Same-cycle implication or plain property.
`define TSC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition now, property in the next cycle.
`define TSC_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) else $error(msg);

`endif

// ===== rtl/tsc_pkg.sv =====
package tsc_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [31:0] word_type;
   typedef logic [5:0]  len_type;
   typedef byte_type    sbox_type [256];

   localparam logic [1:0] MODE_ECB = 2'd0;
   localparam logic [1:0] MODE_CBC = 2'd1;
   localparam logic [1:0] MODE_OFB = 2'd2;

   localparam logic [1:0] REG_KEY  = 2'd0;
   localparam logic [1:0] REG_MODE = 2'd1;
   localparam logic [1:0] REG_DIR  = 2'd2;
   localparam logic [1:0] REG_IV   = 2'd3;

   localparam logic DIR_ENC = 1'b0;
   localparam logic DIR_DEC = 1'b1;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_REFUSED = 1'b1;

   localparam len_type KEY_LIMIT  = 6'd25;
   localparam len_type DATA_LIMIT = 6'd28;

   typedef struct packed {
      word_type kw;
      word_type k1;
      word_type k2;
   } key_set_type;

   typedef struct packed {
      word_type result;
      logic     status;
      logic     chain_we;
      word_type chain_next;
   } core_out_type;

   localparam sbox_type SBOX = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   // Elaboration-time inversion of the permutation.
   function automatic sbox_type build_inv_sbox();
      sbox_type t;
      for (int i = 0; i < 256; i++) begin
         t[SBOX[i]] = byte_type'(i);
      end
      return t;
   endfunction

   localparam sbox_type INV_SBOX = build_inv_sbox();

   function automatic word_type sub_word(word_type v);
      word_type s;
      for (int i = 0; i < 4; i++) begin
         s[8*i +: 8] = SBOX[v[8*i +: 8]];
      end
      return s;
   endfunction

   function automatic word_type inv_sub_word(word_type v);
      word_type s;
      for (int i = 0; i < 4; i++) begin
         s[8*i +: 8] = INV_SBOX[v[8*i +: 8]];
      end
      return s;
   endfunction

   function automatic word_type swap_low(word_type v);
      return {v[31:16], v[7:0], v[15:8]};
   endfunction

   function automatic word_type round_fwd(word_type v, word_type k);
      return swap_low(sub_word(v)) ^ k;
   endfunction

   function automatic word_type round_inv(word_type v, word_type k);
      return inv_sub_word(swap_low(v ^ k));
   endfunction

   // Position of the top set bit plus one; zero for a zero word.
   function automatic len_type bit_length(word_type v);
      len_type n;
      n = '0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) n = len_type'(i + 1);
      end
      return n;
   endfunction

   // Shift left until the top set bit lands in bit 31, for short values only.
   function automatic word_type justify(word_type v, len_type limit);
      len_type n;
      word_type r;
      n = bit_length(v);
      r = v;
      if (n != '0 && n < limit) r = v << (6'd32 - n);
      return r;
   endfunction

   // Mirror over the significant bits only.
   function automatic word_type reverse_sig(word_type v);
      word_type r;
      for (int i = 0; i < 32; i++) begin
         r[i] = v[31 - i];
      end
      return r >> (6'd32 - bit_length(v));
   endfunction

endpackage

// ===== rtl/tsc_core.sv =====
module tsc_core (
   input  tsc_pkg::word_type     data_word,
   input  logic                  first_block,
   input  tsc_pkg::word_type     chain_value,
   input  tsc_pkg::word_type     init_vector,
   input  tsc_pkg::key_set_type  keys,
   input  logic [1:0]            chain_mode,
   input  logic                  direction,
   output tsc_pkg::core_out_type core_out
);

   tsc_pkg::word_type cv;
   tsc_pkg::word_type fwd_in;
   tsc_pkg::word_type fwd_mid;
   tsc_pkg::word_type fwd_out;
   tsc_pkg::word_type inv_mid;
   tsc_pkg::word_type inv_out;
   logic              refuse;

   assign cv     = first_block ? init_vector : chain_value;
   assign refuse = ((chain_mode == tsc_pkg::MODE_CBC) || (chain_mode == tsc_pkg::MODE_OFB))
                   && (init_vector == '0);

   always_comb begin
      unique case (chain_mode)
         tsc_pkg::MODE_CBC: fwd_in = data_word ^ cv ^ keys.kw;
         tsc_pkg::MODE_OFB: fwd_in = cv ^ keys.kw;
         default:           fwd_in = data_word ^ keys.kw;
      endcase
   end

   assign fwd_mid = tsc_pkg::round_fwd(fwd_in, keys.k1);
   assign fwd_out = tsc_pkg::round_fwd(fwd_mid, keys.k2);
   assign inv_mid = tsc_pkg::round_inv(data_word, keys.k2);
   assign inv_out = tsc_pkg::round_inv(inv_mid, keys.k1);

   always_comb begin
      core_out.status   = tsc_pkg::STATUS_OK;
      core_out.chain_we = 1'b1;
      unique case (chain_mode)
         tsc_pkg::MODE_CBC: begin
            if (direction == tsc_pkg::DIR_DEC) begin
               core_out.result     = inv_out ^ keys.kw ^ cv;
               core_out.chain_next = data_word;
            end else begin
               core_out.result     = fwd_out;
               core_out.chain_next = fwd_out;
            end
         end
         tsc_pkg::MODE_OFB: begin
            core_out.result     = fwd_out ^ data_word;
            core_out.chain_next = fwd_out;
         end
         default: begin
            core_out.result     = (direction == tsc_pkg::DIR_DEC) ? (inv_out ^ keys.kw) : fwd_out;
            core_out.chain_next = cv;
         end
      endcase
      // Refused word: zero result, leave the chain alone.
      if (refuse) begin
         core_out.result   = '0;
         core_out.status   = tsc_pkg::STATUS_REFUSED;
         core_out.chain_we = 1'b0;
      end
   end

endmodule

// ===== rtl/toy_sbox_cipher_ecb_cbc_ofb.sv =====
// Two-round 32-bit toy block cipher with ECB, CBC and OFB chaining.
// Input stream req_*: tdata carries the data word, tuser the first-block flag
// that makes the word use the init vector in place of the chain register.
// Result stream rsp_*: tdata carries the result word, tuser the status flag
// (1 when a chained mode meets a zero init vector; the word is then zero).
// Configuration: csr_we, csr_index and csr_wdata write key, mode, direction
// and init vector; the round keys are derived as the key is written.
// Write configuration only while no word is in flight.
// A word accepted into the input register moves on to the result register.
// Throughput: one word per cycle while results are taken; the input register
// feeds both rounds and the chain register closes its loop within that cycle.
// A stalled result holds in the output register; the input register still
// takes one more word, and req_tready drops only when both are full.
// Reset (synchronous, active high) empties both stages, clears key, mode
// and direction, and sets the init vector and the chain register to all ones.
`include "toy_sbox_cipher_ecb_cbc_ofb_macros.svh"

module toy_sbox_cipher_ecb_cbc_ofb (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] data_word
   input  logic [0:0]  req_tuser,   // [0] first_block
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] result_word
   output logic [0:0]  rsp_tuser,   // [0] status
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   tsc_pkg::key_set_type  key_ff, key_in;
   logic [1:0]            mode_ff, mode_in;
   logic                  dir_ff, dir_in;
   tsc_pkg::word_type     iv_ff, iv_in;
   tsc_pkg::word_type     chain_ff, chain_in;

   logic                  in_valid_ff, in_valid_in;
   tsc_pkg::word_type     in_data_ff, in_data_in;
   logic                  in_first_ff, in_first_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   tsc_pkg::word_type     rsp_data_ff, rsp_data_in;
   logic                  rsp_status_ff, rsp_status_in;

   tsc_pkg::word_type     key_rev;
   tsc_pkg::core_out_type core_out;
   logic                  advance;
   logic                  stage_fire;
   logic                  req_fire;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign stage_fire = advance && in_valid_ff;
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   // Configuration writes.
   assign key_rev = tsc_pkg::reverse_sig(csr_wdata);

   always_comb begin
      key_in  = key_ff;
      mode_in = mode_ff;
      dir_in  = dir_ff;
      iv_in   = iv_ff;
      if (csr_we) begin
         unique case (csr_index)
            tsc_pkg::REG_KEY: begin
               key_in.kw = tsc_pkg::justify(csr_wdata, tsc_pkg::KEY_LIMIT);
               key_in.k1 = tsc_pkg::justify(key_rev, tsc_pkg::KEY_LIMIT);
               key_in.k2 = tsc_pkg::justify(key_rev ^ csr_wdata, tsc_pkg::KEY_LIMIT);
            end
            tsc_pkg::REG_MODE: mode_in = csr_wdata[1:0];
            tsc_pkg::REG_DIR:  dir_in  = csr_wdata[0];
            tsc_pkg::REG_IV:   iv_in   = csr_wdata;
            default:           iv_in   = iv_ff;
         endcase
      end
   end

   // Input stage; encrypt inputs are justified on the way in.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      in_first_in = in_first_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_data_in  = (dir_ff == tsc_pkg::DIR_DEC) ? req_tdata
                       : tsc_pkg::justify(req_tdata, tsc_pkg::DATA_LIMIT);
         in_first_in = req_tuser[0];
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   tsc_core u_core (
      .data_word   (in_data_ff),
      .first_block (in_first_ff),
      .chain_value (chain_ff),
      .init_vector (iv_ff),
      .keys        (key_ff),
      .chain_mode  (mode_ff),
      .direction   (dir_ff),
      .core_out    (core_out)
   );

   // Result register and chain update.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      chain_in      = chain_ff;
      if (advance) begin
         rsp_valid_in = in_valid_ff;
      end
      if (stage_fire) begin
         rsp_data_in   = core_out.result;
         rsp_status_in = core_out.status;
         if (core_out.chain_we) chain_in = core_out.chain_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff       <= '0;
         mode_ff      <= tsc_pkg::MODE_ECB;
         dir_ff       <= tsc_pkg::DIR_ENC;
         iv_ff        <= '1;
         chain_ff     <= '1;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_ff       <= key_in;
         mode_ff      <= mode_in;
         dir_ff       <= dir_in;
         iv_ff        <= iv_in;
         chain_ff     <= chain_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff    <= in_data_in;
      in_first_ff   <= in_first_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_status_ff;

   `TSC_ASSERT(a_refused_word_zero, (rsp_valid_ff && (rsp_status_ff == tsc_pkg::STATUS_REFUSED)) |-> (rsp_data_ff == '0), "refused word carries nonzero data")
   `TSC_ASSERT_NEXT(a_refused_keeps_chain, stage_fire && (core_out.status == tsc_pkg::STATUS_REFUSED), $stable(chain_ff), "chain changed on refused word")
   `TSC_ASSERT_NEXT(a_input_holds, in_valid_ff && !advance, in_valid_ff && $stable(in_data_ff), "input stage lost a word while stalled")

endmodule
